### src/uapq_pkg.sv
// ----------------------------------------------------------------------------
// uapq_pkg
// shared types and constants of the unsorted array priority queue
// ----------------------------------------------------------------------------
package uapq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KEY_W   = 32;
  localparam int ACT_W   = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_PEEK   = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic             ok;
  } rsp_t;

endpackage

### src/uapq_if.sv
// ----------------------------------------------------------------------------
// uapq channels
// request and response valid/ready channels of the priority queue
// ----------------------------------------------------------------------------
interface uapq_req_if;
  logic                        valid;
  logic                        ready;
  logic [uapq_pkg::ACT_W-1:0]  action;
  logic [uapq_pkg::KEY_W-1:0]  item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface uapq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [uapq_pkg::KEY_W-1:0]    result_value;
  logic                          ok;
  logic [uapq_pkg::COUNT_W-1:0]  count_now;
  logic                          is_empty;

  modport source (output valid, output result_value, output ok, output count_now,
                  output is_empty, input ready);
  modport sink   (input valid, input result_value, input ok, input count_now,
                  input is_empty, output ready);
endinterface

### src/unsorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue
// max priority queue over an unsorted key array with a tracked maximum
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  req_i    in   action, item_value                        valid/ready
//  rsp_o    out  result_value, ok, count_now, is_empty     valid/ready
//
//  insert, peek and every failing request: response in the cycle after accept
//  remove: one sweep of the key ram, one entry per cycle through its single
//  read port; the response follows once the sweep is done
//  one request in flight: req_i.ready is high only while no response waits
//  reset empties the queue; the key ram itself is never cleared
// ----------------------------------------------------------------------------
module unsorted_array_priority_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  uapq_req_if.sink   req_i,
  uapq_rsp_if.source rsp_o
);
  import uapq_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   max_idx_q, max_idx_d;
  logic [KEY_W-1:0]   max_val_q, max_val_d;
  rsp_t               rsp_q, rsp_d;

  logic [CNT_W-1:0]   scan_q, scan_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [KEY_W-1:0]   rd_data_q;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [KEY_W-1:0]   best_val_q, best_val_d;

  logic [KEY_W-1:0]   mem_q [DEPTH];
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [KEY_W-1:0]   wr_data;

  logic               accept;
  logic               remove_go;
  logic               scan_done;
  logic [IDX_W-1:0]   pos;

  assign accept    = req_i.valid && req_i.ready;
  assign remove_go = (req_i.action == ACT_REMOVE) && (count_q != '0);
  assign scan_done = (scan_q >= count_q) && !rd_vld_q;

  // key ram
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = remove_go ? S_SCAN : S_OUT;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d    = count_q;
    max_idx_d  = max_idx_q;
    max_val_d  = max_val_q;
    rsp_d      = rsp_q;
    scan_d     = scan_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    rd_en      = 1'b0;
    rd_addr    = scan_q[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = count_q[IDX_W-1:0];
    wr_data    = req_i.item_value;
    pos        = (rd_idx_q > max_idx_q) ? IDX_W'(rd_idx_q - 1'b1) : rd_idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d = '0;
          case (req_i.action)
            ACT_INSERT: begin
              if (count_q < CNT_W'(DEPTH)) begin
                wr_en = 1'b1;
                if (count_q == '0 || req_i.item_value > max_val_q) begin
                  max_idx_d = count_q[IDX_W-1:0];
                  max_val_d = req_i.item_value;
                end
                count_d      = count_q + 1'b1;
                rsp_d.ok     = 1'b1;
              end
            end
            ACT_PEEK: begin
              if (count_q != '0) begin
                rsp_d.value = max_val_q;
                rsp_d.ok    = 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (count_q != '0) begin
                rsp_d.value = max_val_q;
                rsp_d.ok    = 1'b1;
                scan_d      = '0;
                found_d     = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // issue one read per cycle over the old contents
        if (scan_q < count_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
          scan_d   = scan_q + 1'b1;
        end
        // word read last cycle: skip the removed slot, close the gap, rescan
        if (rd_vld_q && rd_idx_q != max_idx_q) begin
          if (rd_idx_q > max_idx_q) begin
            wr_en   = 1'b1;
            wr_addr = pos;
            wr_data = rd_data_q;
          end
          if (!found_q || rd_data_q > best_val_q) begin
            found_d    = 1'b1;
            best_idx_d = pos;
            best_val_d = rd_data_q;
          end
        end
        if (scan_done) begin
          count_d   = count_q - 1'b1;
          max_idx_d = found_q ? best_idx_q : '0;
          max_val_d = best_val_q;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      max_idx_q <= '0;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      max_idx_q <= max_idx_d;
      scan_q    <= scan_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_val_q  <= max_val_d;
    rsp_q      <= rsp_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = (state_q == S_OUT);
  assign rsp_o.result_value = rsp_q.value;
  assign rsp_o.ok           = rsp_q.ok;
  assign rsp_o.count_now    = COUNT_W'(count_q);
  assign rsp_o.is_empty     = (count_q == '0);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !rsp_o.valid)
    else $error("request taken while a response waits");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ok) |-> (rsp_o.result_value == '0))
    else $error("failed request carries a key");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && rd_vld_q) |-> (CNT_W'(rd_idx_q) < count_q))
    else $error("sweep read past stored entries");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_done) |=> (count_q == $past(count_q) - 1'b1))
    else $error("remove did not drop one entry");

endmodule

### tb/tb_unsorted_array_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unsorted_array_priority_queue
// self-checking bench: a directed table, then random insert/peek/remove/reserved traffic
// with bursty requests and a stalling response side; each response word is held
// against the table's expected word or else a software copy of the queue
// ----------------------------------------------------------------------------
module tb_unsorted_array_priority_queue;
  import uapq_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;
  localparam int N_RANDOM   = 1700;
  localparam int HOLD_AFTER = 600;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_AT   = 900;
  localparam int TAIL_CYC   = DEPTH + 8;

  typedef struct packed {
    logic [KEY_W-1:0]   value;
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } rsp_word_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    logic [4:0]       rep;
    logic             typed;
    rsp_word_t        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  uapq_req_if req_if ();
  uapq_rsp_if rsp_if ();

  unsorted_array_priority_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // software copy of the queue
  logic [KEY_W-1:0] q_keys [DEPTH];
  int               q_count;
  int               q_max;

  rsp_word_t awaited_rsp [$];
  dir_row_t  dir_tab [$];
  int        n_errors    = 0;
  int        n_accepted  = 0;
  bit        hold_done   = 1'b0;

  task automatic predict_queue_op(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                                  output rsp_word_t res);
    int i;
    int best;
    res = '0;
    case (act)
      ACT_INSERT: begin
        if (q_count < DEPTH) begin
          q_keys[q_count] = key;
          if (q_count == 0 || key > q_keys[q_max]) q_max = q_count;
          q_count++;
          res.ok = 1'b1;
        end
      end
      ACT_PEEK: begin
        if (q_count != 0) begin
          res.value = q_keys[q_max];
          res.ok    = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (q_count != 0) begin
          res.value = q_keys[q_max];
          for (i = q_max; i + 1 < q_count; i++) q_keys[i] = q_keys[i+1];
          q_count--;
          // earliest of equal keys wins
          best = 0;
          for (i = 1; i < q_count; i++) begin
            if (q_keys[i] > q_keys[best]) best = i;
          end
          q_max  = best;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = q_count[COUNT_W-1:0];
    res.empty = (q_count == 0);
  endtask

  // offer one request word at the falling edge, hold it until taken
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                           input logic typed, input rsp_word_t want);
    rsp_word_t pred;
    @(negedge clk);
    req_if.valid      = 1'b1;
    req_if.action     = act;
    req_if.item_value = key;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_queue_op(act, key, pred);
    awaited_rsp.push_back(typed ? want : pred);
    n_accepted++;
  endtask

  task automatic idle_for(input int n);
    @(negedge clk);
    req_if.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic add_row(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                         input int rep, input logic typed, input logic [KEY_W-1:0] v,
                         input logic ok, input int cnt, input logic empty);
    dir_row_t row;
    row.act        = act;
    row.key        = key;
    row.rep        = rep[4:0];
    row.typed      = typed;
    row.want.value = v;
    row.want.ok    = ok;
    row.want.count = cnt[COUNT_W-1:0];
    row.want.empty = empty;
    dir_tab.push_back(row);
  endtask

  // response checker
  always @(posedge clk) begin
    rsp_word_t exp_w;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t: response word with none awaited: value %h ok %b count %0d empty %b",
                 $time, rsp_if.result_value, rsp_if.ok, rsp_if.count_now, rsp_if.is_empty);
        n_errors++;
      end else begin
        exp_w = awaited_rsp.pop_front();
        if (rsp_if.result_value !== exp_w.value) begin
          $display("%0t: result_value expected %h actual %h", $time, exp_w.value,
                   rsp_if.result_value);
          n_errors++;
        end
        if (rsp_if.ok !== exp_w.ok) begin
          $display("%0t: ok expected %b actual %b", $time, exp_w.ok, rsp_if.ok);
          n_errors++;
        end
        if (rsp_if.count_now !== exp_w.count) begin
          $display("%0t: count_now expected %0d actual %0d", $time, exp_w.count,
                   rsp_if.count_now);
          n_errors++;
        end
        if (rsp_if.is_empty !== exp_w.empty) begin
          $display("%0t: is_empty expected %b actual %b", $time, exp_w.empty,
                   rsp_if.is_empty);
          n_errors++;
        end
      end
    end
  end

  // response side: stall patterns that change now and then, plus one long hold-off
  initial begin
    int mode;
    int span;
    int cyc;
    rsp_if.ready = 1'b0;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 200);
      repeat (span) begin
        @(negedge clk);
        cyc++;
        if (!hold_done && n_accepted >= HOLD_AFTER) begin
          rsp_if.ready = 1'b0;
          repeat (HOLD_LEN) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0:       rsp_if.ready = 1'b1;
          1:       rsp_if.ready = 1'($urandom_range(0, 1));
          2:       rsp_if.ready = (cyc % 4 == 0);
          default: rsp_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    rsp_word_t        none;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    int               roll;
    int               phase;
    int               burst_left;
    none              = '0;
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.action     = ACT_INSERT;
    req_if.item_value = '0;
    q_count           = 0;
    q_max             = 0;

    add_row(ACT_PEEK,     0,            1, 1, 0,            0, 0,  1);
    add_row(ACT_REMOVE,   0,            1, 1, 0,            0, 0,  1);
    add_row(ACT_RESERVED, 32'h1234_5678, 1, 1, 0,           0, 0,  1);
    add_row(ACT_INSERT,   0,            1, 1, 0,            1, 1,  0);
    add_row(ACT_PEEK,     0,            1, 1, 0,            1, 1,  0);
    add_row(ACT_INSERT,   '1,           1, 1, 0,            1, 2,  0);
    add_row(ACT_INSERT,   '1,           1, 1, 0,            1, 3,  0);
    add_row(ACT_INSERT,   1,            1, 0, 0,            0, 0,  0);
    add_row(ACT_PEEK,     0,            1, 1, 32'hFFFF_FFFF, 1, 4, 0);
    add_row(ACT_RESERVED, '1,           1, 1, 0,            0, 4,  0);
    add_row(ACT_REMOVE,   0,            1, 1, 32'hFFFF_FFFF, 1, 3, 0);
    add_row(ACT_REMOVE,   0,            1, 1, 32'hFFFF_FFFF, 1, 2, 0);
    add_row(ACT_REMOVE,   0,            1, 0, 0,            0, 0,  0);
    add_row(ACT_REMOVE,   0,            1, 0, 0,            0, 0,  0);
    add_row(ACT_REMOVE,   0,            1, 1, 0,            0, 0,  1);
    add_row(ACT_INSERT,   32'h8000_0000, 1, 0, 0,           0, 0,  0);
    add_row(ACT_INSERT,   32'h7FFF_FFFF, 1, 0, 0,           0, 0,  0);
    add_row(ACT_INSERT,   32'h5555_5555, 7, 0, 0,           0, 0,  0);
    add_row(ACT_INSERT,   32'hAAAA_AAAA, 7, 0, 0,           0, 0,  0);
    // queue is full now
    add_row(ACT_INSERT,   '1,           1, 1, 0,            0, 16, 0);
    add_row(ACT_RESERVED, 0,            1, 1, 0,            0, 16, 0);
    add_row(ACT_PEEK,     0,            1, 1, 32'hAAAA_AAAA, 1, 16, 0);
    add_row(ACT_REMOVE,   0,            16, 0, 0,           0, 0,  0);
    add_row(ACT_PEEK,     0,            1, 1, 0,            0, 0,  1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[r]) begin
      repeat (dir_tab[r].rep) begin
        send_word(dir_tab[r].act, dir_tab[r].key, dir_tab[r].typed, dir_tab[r].want);
      end
    end

    phase      = 2;
    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < N_RANDOM; n++) begin
      // phases: 0 fill, 1 drain, 2 mixed
      if (n % 40 == 0) phase = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 3) act = ACT_RESERVED;
      else if (phase == 0) act = (roll < 75) ? ACT_INSERT : (roll < 88) ? ACT_PEEK : ACT_REMOVE;
      else if (phase == 1) act = (roll < 20) ? ACT_INSERT : (roll < 35) ? ACT_PEEK : ACT_REMOVE;
      else act = (roll < 45) ? ACT_INSERT : (roll < 65) ? ACT_PEEK : ACT_REMOVE;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: key = $urandom;
        5, 6, 7:       key = $urandom_range(0, 7);
        8:             key = $urandom_range(0, 1) ? '1 : '0;
        default:       key = 32'hFFFF_FFF8 | $urandom_range(0, 7);
      endcase

      if (n == DRAIN_AT) begin
        idle_for(1);
        while (awaited_rsp.size() != 0) @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
      end

      send_word(act, key, 1'b0, none);

      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
        burst_left = $urandom_range(1, 30);
      end
    end

    idle_for(1);
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
src/uapq_pkg.sv
src/uapq_if.sv
src/unsorted_array_priority_queue.sv
tb/tb_unsorted_array_priority_queue.sv
